// File: hdl/keyframe_vector_interpolator_core_macros.svh
// Assertion macros for the keyframe vector interpolator core.
`ifndef KEYFRAME_VECTOR_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_VECTOR_INTERPOLATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define KVI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define KVI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kvi_pkg.sv
// Shared types and constants for the keyframe vector interpolator.
`timescale 1ns / 1ps

package kvi_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int IDX_W     = $clog2(MAX_KEYS);
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);
    localparam int TIME_W    = 17;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = DIFF_W + TIME_W + 1;
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int MATH_LAT  = 3;

    // input tdata layout
    localparam int IN_IDX_LO  = 0;
    localparam int IN_TIME_LO = IN_IDX_LO + IDX_W;
    localparam int IN_X_LO    = IN_TIME_LO + TIME_W;
    localparam int IN_Y_LO    = IN_X_LO + VAL_W;
    localparam int IN_Z_LO    = IN_Y_LO + VAL_W;
    localparam int IN_Q_LO    = IN_Z_LO + VAL_W;
    localparam int IN_DATA_W  = ((IN_Q_LO + TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * VAL_W;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LAST   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;

    localparam logic REG_KEY_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_DIV,
        ST_MATH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] tm;
        t_vec              val;
    } t_key_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] b_addr;
    } t_val_rd;

endpackage

// File: hdl/kvi_key_store.sv
// Keyframe time and value memories with registered reads.
`timescale 1ns / 1ps

module kvi_key_store
    import kvi_pkg::*;
(
    input  logic              i_clk,
    input  t_key_wr           i_wr,
    input  logic [IDX_W-1:0]  i_tm_addr,
    input  t_val_rd           i_rd,
    output logic [TIME_W-1:0] o_tm,
    output t_vec              o_va,
    output t_vec              o_vb
);

    logic [TIME_W-1:0] r_tm_mem  [MAX_KEYS];
    t_vec              r_val_mem [MAX_KEYS];
    logic [TIME_W-1:0] r_tm_q;
    t_vec              r_va_q;
    t_vec              r_vb_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tm_mem[i_wr.idx]  <= i_wr.tm;
            r_val_mem[i_wr.idx] <= i_wr.val;
        end
        r_tm_q <= r_tm_mem[i_tm_addr];
        // value ports only move on a fetch so lanes see steady operands
        if (i_rd.en) begin
            r_va_q <= r_val_mem[i_rd.a_addr];
            r_vb_q <= r_val_mem[i_rd.b_addr];
        end
    end

    assign o_tm = r_tm_q;
    assign o_va = r_va_q;
    assign o_vb = r_vb_q;

endmodule

// File: hdl/kvi_divider.sv
// Restoring divider, one quotient bit per cycle, for the Q1.16 blend factor.
`timescale 1ns / 1ps

module kvi_divider
    import kvi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TIME_W-1:0] i_num,
    input  logic [TIME_W-1:0] i_den,
    output logic              o_busy,
    output logic [TIME_W-1:0] o_quo
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W:0]      r_rem;
    logic [TIME_W-1:0]    r_den;
    logic [TIME_W-1:0]    r_quo;

    logic                 ge;
    logic [TIME_W:0]      rem_sel;

    // num <= den, so the quotient fits TIME_W bits and the remainder stays below twice den
    always_comb begin
        ge      = r_rem >= {1'b0, r_den};
        rem_sel = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {rem_sel[TIME_W-1:0], 1'b0};
            r_quo <= {r_quo[TIME_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// File: hdl/kvi_lane.sv
// One vector component lane: a + ((b - a) * t) >>> 16 over three stages.
`timescale 1ns / 1ps

module kvi_lane
    import kvi_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [VAL_W-1:0] i_a,
    input  logic signed [VAL_W-1:0] i_b,
    input  logic [TIME_W-1:0]       i_t,
    output logic signed [VAL_W-1:0] o_res
);

    logic signed [VAL_W-1:0]  r_a1;
    logic signed [DIFF_W-1:0] r_d1;
    logic signed [TIME_W:0]   r_t1;
    logic signed [VAL_W-1:0]  r_a2;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [VAL_W-1:0]  r_res;

    logic signed [PROD_W-1:0] n_p2;
    logic signed [PROD_W-1:0] p_sh;

    always_comb begin
        n_p2 = r_d1 * r_t1;
        p_sh = r_p2 >>> FRAC_W;
    end

    always_ff @(posedge i_clk) begin
        r_a1  <= i_a;
        r_d1  <= DIFF_W'(i_b) - DIFF_W'(i_a);
        r_t1  <= $signed({1'b0, i_t});
        r_a2  <= r_a1;
        r_p2  <= n_p2;
        // result lies between a and b, so wraparound in 32 bits is exact
        r_res <= r_a2 + p_sh[VAL_W-1:0];
    end

    assign o_res = r_res;

endmodule

// File: hdl/keyframe_vector_interpolator_core.sv
// Top level of the keyframe vector interpolator: control, lanes and result merge.
//
// Usage: keyframes are loaded and queried over one input stream (s_axis_*);
// tuser = 0 loads tdata into table entry key_index, tuser = 1 queries at
// query_time. Each query yields one result transaction on m_axis_*: the
// x, y, z vector in tdata and the status code in tuser. Loads yield nothing.
// key_count is set over the APB port at byte address 0; the user must write it
// only while the core idles, and the block itself does not enforce this.
// Flow: a load is written on acceptance. A query scans one time entry per
// cycle, fetches the pair, runs the bit-serial divider (skipped for a zero
// span or no pair), the 3-stage lanes and the merge register. The input
// reopens in the same cycle that tvalid rises. Empty-table queries go from
// idle straight to the result state, skipping scan, fetch, divide and lanes.
// The core takes one item at a time; s_axis_tready is high while idle, also
// while an earlier result still waits in the output register.
// Reset: synchronous, active low; clears key_count and the control state.
// Table contents are kept and are undefined until written.
// Stall: a low m_axis_tready keeps the result registered; a finished query
// waits in its last state until the output register frees up.
`timescale 1ns / 1ps

`include "keyframe_vector_interpolator_core_macros.svh"

module keyframe_vector_interpolator_core
    import kvi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: key_index[6], key_time[17], key_x[32], key_y[32],
    // key_z[32], query_time[17]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: command[1]
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: out_x[32], out_y[32], out_z[32]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[2]
    output logic [STATUS_W-1:0]   m_axis_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]    r_key_count;
    logic [TIME_W-1:0]   r_q;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_idx;
    logic                r_dv;
    logic [IDX_W-1:0]    r_didx;
    logic [TIME_W-1:0]   r_prev_t;
    logic [TIME_W-1:0]   r_t0;
    logic [TIME_W-1:0]   r_t1;
    logic [IDX_W-1:0]    r_pair;
    logic [IDX_W-1:0]    r_pair_b;
    logic [STATUS_W-1:0] r_status;
    logic                r_use_div;
    logic [1:0]          r_math_cnt;
    logic                r_out_valid;
    t_vec                r_out_vec;
    logic [STATUS_W-1:0] r_out_status;

    logic              in_acc;
    logic              is_query;
    logic [CNT_W-1:0]  n_eff;
    logic              hit;
    logic              last;
    logic              out_free;
    logic              out_load;
    logic              cfg_wr;
    t_key_wr           key_wr;
    t_val_rd           val_rd;
    logic [IDX_W-1:0]  tm_addr;
    logic [TIME_W-1:0] tm_q;
    t_vec              va;
    t_vec              vb;
    logic              div_start;
    logic              div_busy;
    logic [TIME_W-1:0] div_quo;
    logic [TIME_W-1:0] lane_t;
    t_vec              lane_res;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KEY_COUNT);
    assign prdata = (paddr[2] == REG_KEY_COUNT) ? {{(32 - CNT_W){1'b0}}, r_key_count} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (cfg_wr) begin
            r_key_count <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------- input decode ----------------
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign is_query = (s_axis_tuser == CMD_QUERY);
    // counts above the table depth clamp to the depth
    assign n_eff    = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : r_key_count;

    assign key_wr.en    = in_acc && (s_axis_tuser == CMD_LOAD);
    assign key_wr.idx   = s_axis_tdata[IN_IDX_LO +: IDX_W];
    assign key_wr.tm    = s_axis_tdata[IN_TIME_LO +: TIME_W];
    assign key_wr.val.x = s_axis_tdata[IN_X_LO +: VAL_W];
    assign key_wr.val.y = s_axis_tdata[IN_Y_LO +: VAL_W];
    assign key_wr.val.z = s_axis_tdata[IN_Z_LO +: VAL_W];

    // ---------------- scan compare ----------------
    // tm_q is time[r_didx]; r_prev_t holds time[r_didx - 1]
    assign hit  = (r_didx != '0) && (r_prev_t <= r_q) && (r_q <= tm_q);
    assign last = ({1'b0, r_didx} == (r_n - 1'b1));

    assign out_free = !r_out_valid || m_axis_tready;
    assign out_load = (r_state == ST_DONE) && out_free;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (n_eff == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_dv && (hit || last)) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = r_use_div ? ST_DIV : ST_MATH;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    n_state = ST_MATH;
                end
            end
            ST_MATH: begin
                if (r_math_cnt == 2'(MATH_LAT - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        tm_addr       = r_idx[IDX_W-1:0];
        val_rd.en     = (r_state == ST_FETCH);
        val_rd.a_addr = r_pair;
        val_rd.b_addr = r_pair_b;
        div_start     = (r_state == ST_FETCH) && r_use_div;
        // zero span and no-pair cases blend with t = 0
        lane_t        = r_use_div ? div_quo : '0;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SCAN) begin
                r_dv <= (r_idx < r_n);
            end else begin
                r_dv <= 1'b0;
            end
        end
    end

    // ---------------- scan datapath ----------------
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && in_acc && is_query) begin
            r_q      <= s_axis_tdata[IN_Q_LO +: TIME_W];
            r_n      <= n_eff;
            r_idx    <= '0;
            r_status <= (n_eff == '0) ? STAT_EMPTY : STAT_INTERP;
        end
        if (r_state == ST_SCAN) begin
            if (r_idx < r_n) begin
                r_idx  <= r_idx + 1'b1;
                r_didx <= r_idx[IDX_W-1:0];
            end
            if (r_dv) begin
                r_prev_t <= tm_q;
                if (hit) begin
                    r_pair    <= r_didx - 1'b1;
                    r_pair_b  <= r_didx;
                    r_t0      <= r_prev_t;
                    r_t1      <= tm_q;
                    r_status  <= STAT_INTERP;
                    r_use_div <= (tm_q != r_prev_t);
                end else if (last) begin
                    r_pair    <= r_didx;
                    r_pair_b  <= r_didx;
                    r_status  <= STAT_LAST;
                    r_use_div <= 1'b0;
                end
            end
        end
        if (r_state == ST_MATH) begin
            r_math_cnt <= r_math_cnt + 1'b1;
        end else begin
            r_math_cnt <= '0;
        end
    end

    // ---------------- submodules ----------------
    kvi_key_store u_store (
        .i_clk     (i_clk),
        .i_wr      (key_wr),
        .i_tm_addr (tm_addr),
        .i_rd      (val_rd),
        .o_tm      (tm_q),
        .o_va      (va),
        .o_vb      (vb)
    );

    kvi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_q - r_t0),
        .i_den   (r_t1 - r_t0),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    kvi_lane u_lane_x (
        .i_clk (i_clk),
        .i_a   (va.x),
        .i_b   (vb.x),
        .i_t   (lane_t),
        .o_res (lane_res.x)
    );

    kvi_lane u_lane_y (
        .i_clk (i_clk),
        .i_a   (va.y),
        .i_b   (vb.y),
        .i_t   (lane_t),
        .o_res (lane_res.y)
    );

    kvi_lane u_lane_z (
        .i_clk (i_clk),
        .i_a   (va.z),
        .i_b   (vb.z),
        .i_t   (lane_t),
        .o_res (lane_res.z)
    );

    // ---------------- merge and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_vec    <= (r_status == STAT_EMPTY) ? '0 : lane_res;
            r_out_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_vec.z, r_out_vec.y, r_out_vec.x};
    assign m_axis_tuser  = r_out_status;

    // ---------------- assertions ----------------
    `KVI_ASSERT_NEXT(a_empty_direct, (in_acc && is_query && (n_eff == '0)), ((r_state == ST_DONE) && (r_status == STAT_EMPTY)), "empty-table query did not go straight to result")
    `KVI_ASSERT_SAME(a_div_done, (r_state == ST_MATH), (!div_busy), "lanes started before divider finished")
    `KVI_ASSERT_NEXT(a_hold_done, ((r_state == ST_DONE) && r_out_valid && !m_axis_tready), (r_state == ST_DONE), "result left while output register was full")
    `KVI_ASSERT_SAME(a_pair_range, ((r_state == ST_FETCH) && (r_status == STAT_INTERP)), (({1'b0, r_pair} + 1'b1) < r_n), "bracketing pair beyond key count")

endmodule
